/* sv/srpg_pkg.sv */
// ----------------------------------------------------------------------------
// srpg_pkg: shared types and constants
// Item structs, command and status bundles, fixed-point constants.
// ----------------------------------------------------------------------------
package srpg_pkg;

  localparam int UNITS      = 8;
  localparam int UNIT_W     = 3;
  localparam int TICK_HZ    = 100000;
  localparam int STEP_BITS  = 24;
  localparam int FREQ_SHIFT = 14;

  localparam int CF_W   = 39;  // current frequency, Q17.22 unsigned
  localparam int FS_W   = 40;  // frequency step, Q18.22 signed
  localparam int THR_W  = 26;  // accel threshold, signed
  localparam int PER_W  = 17;
  localparam int CNT_W  = 18;
  localparam int FRAC_W = 16;
  localparam int DVN_W  = 41;  // divider dividend / quotient
  localparam int DVD_W  = 25;  // divider divisor
  localparam int DCNT_W = 6;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_MOVE  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  localparam logic [7:0]       UNIT_MASK       = 8'((1 << UNITS) - 1);
  localparam logic [DVN_W-1:0] PERIOD_DIVIDEND = DVN_W'(TICK_HZ) << 24;
  localparam logic [CF_W-1:0]  ONE_HZ          = CF_W'(256) << FREQ_SHIFT;
  localparam logic [CF_W-1:0]  MAX_FREQ        = {25'h1FFFFFF, 14'd0};

  typedef struct packed {
    logic [1:0]           kind;
    logic [2:0]           unit;
    logic                 direction;
    logic [STEP_BITS-1:0] step_count;
    logic [STEP_BITS-1:0] ramp_steps;
    logic [24:0]          start_freq;
    logic [24:0]          end_freq;
    logic [7:0]           start_mask;
  } in_item_t;

  typedef struct packed {
    logic [7:0] step_mask;
    logic [7:0] dir_set_mask;
    logic [7:0] dir_clear_mask;
    logic [7:0] done_mask;
    logic [7:0] running_mask;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MV_LOAD,
    ST_MV_SDIV,
    ST_PER_START,
    ST_PER_WAIT,
    ST_TK_EVAL,
    ST_TK_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic              latch;
    logic              start_units;
    logic              clear_masks;
    logic              mv_load;
    logic              div_start;
    logic              div_sel_period;
    logic              step_wr;
    logic              period_wr;
    logic              tk_eval;
    logic              out_load;
    logic [UNIT_W-1:0] unit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ramp_zero;
    logic need_div;
  } dp_stat_t;

endpackage

/* sv/srpg_div.sv */
// ----------------------------------------------------------------------------
// srpg_div: shared unsigned divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srpg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [srpg_pkg::DVN_W-1:0] dividend,
  input  logic [srpg_pkg::DVD_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [srpg_pkg::DVN_W-1:0] quotient
);

  logic [srpg_pkg::DVN_W-1:0]  quo_r, quo_nxt;
  logic [srpg_pkg::DVD_W-1:0]  rem_r, rem_nxt;
  logic [srpg_pkg::DVD_W-1:0]  dvs_r;
  logic [srpg_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [srpg_pkg::DVD_W:0]    shifted;
  logic [srpg_pkg::DVD_W+1:0]  trial;
  logic                        ge;

  always_comb begin
    shifted = {rem_r, quo_r[srpg_pkg::DVN_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs_r};
    ge      = ~trial[srpg_pkg::DVD_W+1];
    rem_nxt = ge ? trial[srpg_pkg::DVD_W-1:0] : shifted[srpg_pkg::DVD_W-1:0];
    quo_nxt = {quo_r[srpg_pkg::DVN_W-2:0], ge};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == srpg_pkg::DCNT_W'(srpg_pkg::DVN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* sv/srpg_dp.sv */
// ----------------------------------------------------------------------------
// srpg_dp: per-unit ramp datapath
// Unit state registers, tick evaluation, move load and result register.
// ----------------------------------------------------------------------------
module srpg_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  srpg_pkg::in_item_t         in_data,
  input  srpg_pkg::ctrl_cmd_t        cmd,
  output srpg_pkg::dp_stat_t         stat,
  output logic [srpg_pkg::DVN_W-1:0] div_dividend,
  output logic [srpg_pkg::DVD_W-1:0] div_divisor,
  input  logic                       div_done,
  input  logic [srpg_pkg::DVN_W-1:0] div_quotient,
  output srpg_pkg::out_item_t        out_data
);

  srpg_pkg::in_item_t item_r;

  logic [7:0]                        running_r;
  logic [srpg_pkg::STEP_BITS-1:0]    rem_r     [srpg_pkg::UNITS];
  logic signed [srpg_pkg::THR_W-1:0] acc_thr_r [srpg_pkg::UNITS];
  logic [srpg_pkg::STEP_BITS-1:0]    dec_thr_r [srpg_pkg::UNITS];
  logic [srpg_pkg::CF_W-1:0]         cf_r      [srpg_pkg::UNITS];
  logic signed [srpg_pkg::FS_W-1:0]  fs_r      [srpg_pkg::UNITS];
  logic [srpg_pkg::PER_W-1:0]        per_r     [srpg_pkg::UNITS];
  logic signed [srpg_pkg::CNT_W-1:0] cnt_r     [srpg_pkg::UNITS];
  logic [srpg_pkg::FRAC_W-1:0]       frac_r    [srpg_pkg::UNITS];
  logic [srpg_pkg::FRAC_W:0]         facc_r    [srpg_pkg::UNITS];
  logic [7:0]                        dir_r;

  logic [7:0] step_m_r, dset_m_r, dclr_m_r, stop_m_r;
  srpg_pkg::out_item_t out_r;

  // move load terms
  logic [srpg_pkg::STEP_BITS-1:0] mv_n;
  logic signed [25:0]             mv_diff;
  logic [24:0]                    mv_mag;
  logic                           mv_neg;
  logic [srpg_pkg::FS_W-1:0]      fs_pos;

  // tick terms for the selected unit
  logic [srpg_pkg::UNIT_W-1:0]       u;
  logic                              t_run, t_hit, t_carry, t_last, t_accel, t_decel;
  logic signed [srpg_pkg::CNT_W-1:0] t_cnt_inc;
  logic [srpg_pkg::FRAC_W:0]         t_fsum;
  logic signed [41:0]                t_cf_plus, t_cf_minus, t_cf_new;
  logic [srpg_pkg::CF_W-1:0]         t_cf_clamp;
  logic [24:0]                       f8;

  assign u = cmd.unit;

  always_comb begin
    mv_n    = (item_r.step_count == '0) ? srpg_pkg::STEP_BITS'(1) : item_r.step_count;
    mv_diff = $signed({1'b0, item_r.end_freq}) - $signed({1'b0, item_r.start_freq});
    mv_neg  = mv_diff[25];
    mv_mag  = mv_neg ? 25'(-mv_diff) : mv_diff[24:0];
    fs_pos  = div_quotient[srpg_pkg::FS_W-1:0];
  end

  always_comb begin
    t_run     = running_r[u];
    t_cnt_inc = cnt_r[u] + srpg_pkg::CNT_W'(1);
    t_hit     = t_run && (t_cnt_inc == $signed({1'b0, per_r[u]}));
    t_fsum    = facc_r[u] + {1'b0, frac_r[u]};
    t_carry   = t_fsum[srpg_pkg::FRAC_W];
    t_last    = rem_r[u] <= srpg_pkg::STEP_BITS'(1);
    t_accel   = $signed({2'b00, rem_r[u]}) >= acc_thr_r[u];
    t_decel   = rem_r[u] <= dec_thr_r[u];
    t_cf_plus  = $signed({3'b000, cf_r[u]}) + 42'(fs_r[u]);
    t_cf_minus = $signed({3'b000, cf_r[u]}) - 42'(fs_r[u]);
    t_cf_new   = t_accel ? t_cf_plus : t_cf_minus;
    if (t_cf_new < $signed({3'b000, srpg_pkg::ONE_HZ})) begin
      t_cf_clamp = srpg_pkg::ONE_HZ;
    end else if (t_cf_new > $signed({3'b000, srpg_pkg::MAX_FREQ})) begin
      t_cf_clamp = srpg_pkg::MAX_FREQ;
    end else begin
      t_cf_clamp = t_cf_new[srpg_pkg::CF_W-1:0];
    end
  end

  assign stat.ramp_zero = (item_r.ramp_steps == '0);
  assign stat.need_div  = t_hit && !t_last && (t_accel || t_decel);

  // raise the period divisor to 1 Hz
  always_comb begin
    f8 = cf_r[u][srpg_pkg::CF_W-1:srpg_pkg::FREQ_SHIFT];
    if (f8 < 25'd256) begin
      f8 = 25'd256;
    end
    if (cmd.div_sel_period) begin
      div_dividend = srpg_pkg::PERIOD_DIVIDEND;
      div_divisor  = f8;
    end else begin
      div_dividend = {2'b00, mv_mag, 14'd0};
      div_divisor  = {1'b0, item_r.ramp_steps};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (cmd.out_load) begin
      out_r <= '{step_mask: step_m_r, dir_set_mask: dset_m_r, dir_clear_mask: dclr_m_r,
                 done_mask: stop_m_r, running_mask: running_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
      dir_r     <= '0;
      step_m_r  <= '0;
      dset_m_r  <= '0;
      dclr_m_r  <= '0;
      stop_m_r  <= '0;
      for (int i = 0; i < srpg_pkg::UNITS; i++) begin
        rem_r[i]     <= '0;
        acc_thr_r[i] <= '0;
        dec_thr_r[i] <= '0;
        cf_r[i]      <= '0;
        fs_r[i]      <= '0;
        per_r[i]     <= srpg_pkg::PER_W'(1);
        cnt_r[i]     <= '0;
        frac_r[i]    <= '0;
        facc_r[i]    <= '0;
      end
    end else begin
      if (cmd.start_units) begin
        running_r <= running_r | (in_data.start_mask & srpg_pkg::UNIT_MASK);
      end
      if (cmd.clear_masks) begin
        step_m_r <= '0;
        dset_m_r <= '0;
        dclr_m_r <= '0;
        stop_m_r <= '0;
      end
      if (cmd.mv_load) begin
        rem_r[u]     <= mv_n;
        acc_thr_r[u] <= $signed({2'b00, mv_n}) - $signed({2'b00, item_r.ramp_steps})
                        + srpg_pkg::THR_W'(1);
        dec_thr_r[u] <= item_r.ramp_steps;
        cf_r[u]      <= stat.ramp_zero ? {item_r.end_freq, 14'd0}
                                       : {item_r.start_freq, 14'd0};
        fs_r[u]      <= '0;
        dir_r[u]     <= item_r.direction;
        facc_r[u]    <= '0;
        cnt_r[u]     <= '0;
      end
      if (cmd.step_wr && div_done) begin
        fs_r[u] <= mv_neg ? -$signed(fs_pos) : $signed(fs_pos);
      end
      if (cmd.period_wr && div_done) begin
        if (div_quotient < srpg_pkg::DVN_W'(65536)) begin
          per_r[u]  <= srpg_pkg::PER_W'(1);
          frac_r[u] <= '0;
        end else begin
          per_r[u]  <= div_quotient[32:16];
          frac_r[u] <= div_quotient[15:0];
        end
      end
      if (cmd.tk_eval && t_run) begin
        if (!t_hit) begin
          cnt_r[u] <= t_cnt_inc;
        end else begin
          // carry past one whole tick: stretch the next period by one
          cnt_r[u]    <= t_carry ? -srpg_pkg::CNT_W'(1) : '0;
          facc_r[u]   <= {1'b0, t_fsum[srpg_pkg::FRAC_W-1:0]};
          step_m_r[u] <= 1'b1;
          dset_m_r[u] <= dir_r[u];
          dclr_m_r[u] <= ~dir_r[u];
          if (t_last) begin
            running_r[u] <= 1'b0;
            stop_m_r[u]  <= 1'b1;
          end else begin
            if (t_accel || t_decel) begin
              cf_r[u] <= t_cf_clamp;
            end
            rem_r[u] <= rem_r[u] - srpg_pkg::STEP_BITS'(1);
          end
        end
      end
    end
  end

  assign out_data = out_r;

endmodule

/* sv/srpg_ctrl.sv */
// ----------------------------------------------------------------------------
// srpg_ctrl: sequencing controller
// Decodes items, walks the units on a tick and schedules divisions.
// ----------------------------------------------------------------------------
module srpg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_kind,
  input  logic [2:0]           in_unit,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  srpg_pkg::dp_stat_t   stat,
  input  logic                 div_done,
  output srpg_pkg::ctrl_cmd_t  cmd
);

  srpg_pkg::ctrl_state_t       state_r, state_nxt;
  logic [srpg_pkg::UNIT_W-1:0] unit_r, unit_nxt;
  logic                        tick_r, tick_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        accept, unit_ok, last_unit, out_free;

  assign accept    = in_valid && (state_r == srpg_pkg::ST_IDLE);
  assign unit_ok   = {1'b0, in_unit} < 4'(srpg_pkg::UNITS);
  assign last_unit = unit_r == srpg_pkg::UNIT_W'(srpg_pkg::UNITS - 1);
  assign out_free  = !(out_valid_r && out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    unit_nxt  = unit_r;
    tick_nxt  = tick_r;
    unique case (state_r)
      srpg_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_kind == srpg_pkg::KIND_MOVE && unit_ok) begin
            state_nxt = srpg_pkg::ST_MV_LOAD;
            unit_nxt  = in_unit[srpg_pkg::UNIT_W-1:0];
            tick_nxt  = 1'b0;
          end else if (in_kind == srpg_pkg::KIND_TICK) begin
            state_nxt = srpg_pkg::ST_TK_EVAL;
            unit_nxt  = '0;
            tick_nxt  = 1'b1;
          end
        end
      end
      srpg_pkg::ST_MV_LOAD: begin
        state_nxt = stat.ramp_zero ? srpg_pkg::ST_PER_START : srpg_pkg::ST_MV_SDIV;
      end
      srpg_pkg::ST_MV_SDIV: begin
        if (div_done) begin
          state_nxt = srpg_pkg::ST_PER_START;
        end
      end
      srpg_pkg::ST_PER_START: begin
        state_nxt = srpg_pkg::ST_PER_WAIT;
      end
      srpg_pkg::ST_PER_WAIT: begin
        if (div_done) begin
          if (!tick_r) begin
            state_nxt = srpg_pkg::ST_IDLE;
          end else if (last_unit) begin
            state_nxt = srpg_pkg::ST_TK_OUT;
          end else begin
            state_nxt = srpg_pkg::ST_TK_EVAL;
            unit_nxt  = unit_r + 1'b1;
          end
        end
      end
      srpg_pkg::ST_TK_EVAL: begin
        if (stat.need_div) begin
          state_nxt = srpg_pkg::ST_PER_START;
        end else if (last_unit) begin
          state_nxt = srpg_pkg::ST_TK_OUT;
        end else begin
          unit_nxt = unit_r + 1'b1;
        end
      end
      srpg_pkg::ST_TK_OUT: begin
        if (out_free) begin
          state_nxt = srpg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = srpg_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.unit = unit_r;
    unique case (state_r)
      srpg_pkg::ST_IDLE: begin
        cmd.latch       = accept;
        cmd.start_units = accept && (in_kind == srpg_pkg::KIND_START);
        cmd.clear_masks = accept && (in_kind == srpg_pkg::KIND_TICK);
      end
      srpg_pkg::ST_MV_LOAD: begin
        cmd.mv_load   = 1'b1;
        cmd.div_start = !stat.ramp_zero;
      end
      srpg_pkg::ST_MV_SDIV: begin
        cmd.step_wr = 1'b1;
      end
      srpg_pkg::ST_PER_START: begin
        cmd.div_start      = 1'b1;
        cmd.div_sel_period = 1'b1;
      end
      srpg_pkg::ST_PER_WAIT: begin
        cmd.div_sel_period = 1'b1;
        cmd.period_wr      = 1'b1;
      end
      srpg_pkg::ST_TK_EVAL: begin
        cmd.tk_eval = 1'b1;
      end
      srpg_pkg::ST_TK_OUT: begin
        cmd.out_load = out_free;
      end
      default: cmd.unit = unit_r;
    endcase
  end

  // hold the beat until taken
  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srpg_pkg::ST_IDLE;
      unit_r      <= '0;
      tick_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      unit_r      <= unit_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != srpg_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* sv/stepper_ramp_pulse_generator.sv */
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator: multi-axis stepper ramp pulse generator
// One item at a time; the step and period divisions share one divider.
// Move item: a period division, preceded by a step division when the ramp is
// non-zero. Tick item: the units are evaluated in turn, with a period division
// for each pulsing unit whose period changes; a stalled result holds the next
// tick. Synchronous active-low reset clears the control and unit state; the
// item, result and divider operand registers are not reset.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  srpg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srpg_pkg::out_item_t out_data
);

  srpg_pkg::ctrl_cmd_t        cmd;
  srpg_pkg::dp_stat_t         stat;
  logic [srpg_pkg::DVN_W-1:0] div_dividend, div_quotient;
  logic [srpg_pkg::DVD_W-1:0] div_divisor;
  logic                       div_busy, div_done;

  srpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_unit   (in_data.unit),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .div_done  (div_done),
    .cmd       (cmd)
  );

  srpg_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_data),
    .cmd          (cmd),
    .stat         (stat),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .out_data     (out_data)
  );

  srpg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> in_stall)
    else $error("divider running while input is open");

  a_stop_not_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.done_mask & out_data.running_mask) == 8'd0))
    else $error("stopped unit still running");

  a_dir_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (((out_data.dir_set_mask | out_data.dir_clear_mask)
                    == out_data.step_mask)
                   && ((out_data.dir_set_mask & out_data.dir_clear_mask) == 8'd0)))
    else $error("direction masks do not split step mask");

endmodule

/* tb/tb_stepper_ramp_pulse_generator.sv */
// ----------------------------------------------------------------------------
// tb_stepper_ramp_pulse_generator: self-checking bench for the ramp generator
// Drives move, start and tick beats under varying idle and stall patterns,
// predicts every tick's step, direction, stop and running masks in a local
// per-unit ramp model, and compares each result beat in order.
// ----------------------------------------------------------------------------
module tb_stepper_ramp_pulse_generator;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 500;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  srpg_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  srpg_pkg::out_item_t out_data;

  stepper_ramp_pulse_generator dut (.*);

  // unit state for mask prediction
  logic [7:0]  run_bits;
  int unsigned steps_left [srpg_pkg::UNITS];
  longint      accel_at [srpg_pkg::UNITS];
  longint      decel_at [srpg_pkg::UNITS];
  longint      freq_q22 [srpg_pkg::UNITS];
  longint      ramp_inc [srpg_pkg::UNITS];
  int unsigned period_whole [srpg_pkg::UNITS];
  int          tick_cnt [srpg_pkg::UNITS];
  int unsigned period_frac [srpg_pkg::UNITS];
  int unsigned frac_acc [srpg_pkg::UNITS];
  bit          dir_lvl [srpg_pkg::UNITS];

  srpg_pkg::in_item_t  pending_q [$];
  srpg_pkg::out_item_t masks_q [$];
  int        errors = 0;
  int        ticks_sent = 0;
  int        moves_sent = 0;
  int        results_seen = 0;
  int        pulses_seen = 0;
  int        stops_seen = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        send_en = 1'b0;
  bit        hold_go = 1'b0;
  int        hold_cnt = 0;
  int        cycles = 0;

  function automatic void clear_units();
    run_bits = '0;
    for (int u = 0; u < srpg_pkg::UNITS; u++) begin
      steps_left[u] = 0; accel_at[u] = 0; decel_at[u] = 0;
      freq_q22[u] = 0; ramp_inc[u] = 0; period_whole[u] = 1;
      tick_cnt[u] = 0; period_frac[u] = 0; frac_acc[u] = 0; dir_lvl[u] = 0;
    end
  endfunction

  function automatic void update_period(int u);
    longint f8;
    longint q;
    f8 = freq_q22[u] >>> srpg_pkg::FREQ_SHIFT;
    if (f8 < 256) f8 = 256;
    q = (longint'(srpg_pkg::TICK_HZ) << 24) / f8;
    if (q < 65536) begin
      period_whole[u] = 1;
      period_frac[u] = 0;
    end else begin
      period_whole[u] = int'(q >> 16);
      period_frac[u] = int'(q & 64'hFFFF);
    end
  endfunction

  function automatic void apply_beat(srpg_pkg::in_item_t it);
    srpg_pkg::out_item_t r;
    longint    n, rs, sf, ef;
    int        u;
    if (it.kind == srpg_pkg::KIND_MOVE) begin
      u = it.unit;
      n = it.step_count;
      rs = it.ramp_steps;
      sf = it.start_freq;
      ef = it.end_freq;
      if (n == 0) n = 1;
      steps_left[u] = int'(n);
      accel_at[u] = n - rs + 1;
      decel_at[u] = rs;
      if (rs > 0) begin
        freq_q22[u] = sf << srpg_pkg::FREQ_SHIFT;
        ramp_inc[u] = ((ef - sf) * 16384) / rs;
      end else begin
        freq_q22[u] = ef << srpg_pkg::FREQ_SHIFT;
        ramp_inc[u] = 0;
      end
      dir_lvl[u] = it.direction;
      frac_acc[u] = 0;
      tick_cnt[u] = 0;
      update_period(u);
      return;
    end
    if (it.kind == srpg_pkg::KIND_START) begin
      run_bits |= it.start_mask & srpg_pkg::UNIT_MASK;
      return;
    end
    if (it.kind != srpg_pkg::KIND_TICK) return;
    r = '0;
    for (u = 0; u < srpg_pkg::UNITS; u++) begin
      if (!run_bits[u]) continue;
      tick_cnt[u]++;
      if (tick_cnt[u] != int'(period_whole[u])) continue;
      frac_acc[u] += period_frac[u];
      if (frac_acc[u] >= 65536) begin
        frac_acc[u] -= 65536;
        tick_cnt[u] = -1;
      end else begin
        tick_cnt[u] = 0;
      end
      r.step_mask[u] = 1'b1;
      if (dir_lvl[u]) r.dir_set_mask[u] = 1'b1;
      else r.dir_clear_mask[u] = 1'b1;
      if (steps_left[u] <= 1) begin
        run_bits[u] = 1'b0;
        r.done_mask[u] = 1'b1;
        continue;
      end
      if (longint'(steps_left[u]) >= accel_at[u] ||
          longint'(steps_left[u]) <= decel_at[u]) begin
        if (longint'(steps_left[u]) >= accel_at[u]) freq_q22[u] += ramp_inc[u];
        else freq_q22[u] -= ramp_inc[u];
        if (freq_q22[u] < longint'(srpg_pkg::ONE_HZ)) freq_q22[u] = longint'(srpg_pkg::ONE_HZ);
        if (freq_q22[u] > longint'(srpg_pkg::MAX_FREQ)) begin
          freq_q22[u] = longint'(srpg_pkg::MAX_FREQ);
        end
        update_period(u);
      end
      steps_left[u]--;
    end
    r.running_mask = run_bits;
    masks_q.push_back(r);
  endfunction

  function automatic srpg_pkg::in_item_t mk_move(int u, bit d, int n, int rs, int sf, int ef);
    srpg_pkg::in_item_t it;
    it = srpg_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.kind = srpg_pkg::KIND_MOVE; it.unit = 3'(u); it.direction = d;
    it.step_count = 24'(n); it.ramp_steps = 24'(rs);
    it.start_freq = 25'(sf); it.end_freq = 25'(ef);
    return it;
  endfunction

  function automatic srpg_pkg::in_item_t mk_start(logic [7:0] m);
    srpg_pkg::in_item_t it;
    it = srpg_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.kind = srpg_pkg::KIND_START;
    it.start_mask = m;
    return it;
  endfunction

  function automatic srpg_pkg::in_item_t mk_tick();
    srpg_pkg::in_item_t it;
    it = srpg_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.kind = srpg_pkg::KIND_TICK;
    return it;
  endfunction

  function automatic srpg_pkg::in_item_t mk_reserved();
    srpg_pkg::in_item_t it;
    it = srpg_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.kind = srpg_pkg::KIND_RSVD;
    return it;
  endfunction

  function automatic int pick_freq();
    case ($urandom_range(19))
      0: return 0;
      1: return 256;
      2: return 25600000;
      3: return 25'h1FFFFFF;
      4: return $urandom & 25'h1FFFFFF;
      default: return $urandom_range(256 * 3000, 256 * 150000);
    endcase
  endfunction

  // one move-start-ticks sequence, with some noise mixed in
  task automatic add_sequence();
    int moves;
    logic [7:0] m;
    moves = $urandom_range(1, 3);
    m = '0;
    for (int i = 0; i < moves; i++) begin
      int u;
      int n;
      u = $urandom_range(srpg_pkg::UNITS - 1);
      n = ($urandom_range(30) == 0) ? ($urandom & 24'hFFFFFF) : $urandom_range(0, 24);
      pending_q.push_back(mk_move(u, 1'($urandom_range(1)), n,
                                  ($urandom_range(30) == 0) ? ($urandom & 24'hFFFFFF)
                                                            : $urandom_range(0, 10),
                                  pick_freq(), pick_freq()));
      m[u] = 1'b1;
    end
    if ($urandom_range(9) == 0) m = 8'($urandom);
    pending_q.push_back(mk_start(m));
    repeat ($urandom_range(4, 30)) begin
      case ($urandom_range(24))
        0: pending_q.push_back(srpg_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom}));
        1: pending_q.push_back(mk_start(8'($urandom)));
        default: pending_q.push_back(mk_tick());
      endcase
    end
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("[stepper_ramp_pulse_generator] ERROR");
      $finish;
    end
  end

  // driver: advance only when the current beat went through
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_beat(in_data);
        if (in_data.kind == srpg_pkg::KIND_TICK) ticks_sent <= ticks_sent + 1;
        if (in_data.kind == srpg_pkg::KIND_MOVE) moves_sent <= moves_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_en && pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_go) hold_cnt <= HOLD_CYCLES;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  always @(posedge clk) begin
    out_stall <= (hold_cnt > 0) || ($urandom_range(99) < recv_idle_pct);
  end

  task automatic check_mask(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %02h, got %02h", name, exp_v, got_v);
      errors++;
    end
  endtask

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (masks_q.size() == 0) begin
        $error("result beat with no tick pending: %h", out_data);
        errors++;
      end else begin
        srpg_pkg::out_item_t e;
        e = masks_q.pop_front();
        check_mask("step_mask", e.step_mask, out_data.step_mask);
        check_mask("dir_set_mask", e.dir_set_mask, out_data.dir_set_mask);
        check_mask("dir_clear_mask", e.dir_clear_mask, out_data.dir_clear_mask);
        check_mask("done_mask", e.done_mask, out_data.done_mask);
        check_mask("running_mask", e.running_mask, out_data.running_mask);
        pulses_seen += $countones(out_data.step_mask);
        stops_seen += $countones(out_data.done_mask);
      end
      results_seen++;
    end
  end

  initial begin
    int send_pct [4];
    int recv_pct [4];
    send_pct = '{0, 61, 0, 11};
    recv_pct = '{0, 0, 61, 11};
    clear_units();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: idle ticks, extremes, restart, ignored kind
    pending_q.push_back(mk_tick());
    pending_q.push_back(mk_move(0, 1'b1, 0, 0, 25600000, 25600000));
    pending_q.push_back(mk_start(8'h01));
    repeat (3) pending_q.push_back(mk_tick());
    pending_q.push_back(mk_start(8'h01));
    repeat (2) pending_q.push_back(mk_tick());
    pending_q.push_back(mk_move(7, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 25'h1FFFFFF, 0));
    pending_q.push_back(mk_move(6, 1'b1, 3, 0, 0, 256));
    pending_q.push_back(mk_move(1, 1'b0, 6, 2, 256 * 20000, 256 * 100000));
    pending_q.push_back(mk_start(8'hFF));
    pending_q.push_back(mk_reserved());
    repeat (8) pending_q.push_back(mk_tick());
    pending_q.push_back(mk_move(1, 1'b1, 4, 1, 256 * 100000, 256 * 40000));
    repeat (4) pending_q.push_back(mk_tick());

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      while (pending_q.size() < 400) add_sequence();
      send_en = 1'b1;
      if (ph == 0) begin
        // long receiver hold while the sender keeps offering beats
        repeat (200) @(negedge clk);
        hold_go = 1'b1;
        @(negedge clk);
        hold_go = 1'b0;
      end
      while (pending_q.size() > 0 || in_valid || masks_q.size() > 0) @(negedge clk);
      send_en = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (masks_q.size() != 0) begin
      $error("%0d tick results never arrived", masks_q.size());
      errors++;
    end
    $display("covered %0d ticks and %0d moves; %0d results, %0d pulses, %0d stops",
             ticks_sent, moves_sent, results_seen, pulses_seen, stops_seen);
    $display("idle phases: none, sender, receiver, both; one long receiver hold");
    if (errors == 0) begin
      $display("[stepper_ramp_pulse_generator] OK");
    end else begin
      $display("[stepper_ramp_pulse_generator] ERROR");
    end
    $finish;
  end

endmodule
